### sv/framed_motor_command_parser_defines.svh
// assertion macros used by the parser top file
`ifndef FRAMED_MOTOR_COMMAND_PARSER_DEFINES_SVH
`define FRAMED_MOTOR_COMMAND_PARSER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FMCP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FMCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/fmcp_pkg.sv
package fmcp_pkg;

  // frame bytes
  localparam logic [7:0] HdrByte     = 8'hFF;
  localparam logic [7:0] CmdSpeed    = 8'hFE;
  localparam logic [7:0] CmdPosition = 8'hFD;
  localparam logic [7:0] CmdVoltage  = 8'hFC;
  localparam logic [7:0] CmdBrake    = 8'hFB;
  localparam logic [7:0] FtrByte     = 8'hAA;

  // control modes
  localparam logic [2:0] ModeStop     = 3'd0;
  localparam logic [2:0] ModeSpeed    = 3'd1;
  localparam logic [2:0] ModePosition = 3'd2;
  localparam logic [2:0] ModeVoltage  = 3'd3;
  localparam logic [2:0] ModeBrake    = 3'd4;

  // item kinds
  localparam logic KindByte = 1'b0;
  localparam logic KindTick = 1'b1;

  localparam logic [15:0] TimeoutResetTicks = 16'd500;
  localparam logic [15:0] SilenceMax        = 16'hFFFF;
  localparam int unsigned NumTargets        = 4;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         control_mode;
    logic signed [15:0] speed_target;
    logic signed [15:0] position_target;
    logic signed [15:0] voltage_target;
    logic signed [15:0] brake_target;
    logic               frame_accepted;
    logic               timed_out;
    logic               link_led;
  } out_item_t;

  // what the frame decoder reports for one received byte
  typedef struct packed {
    logic        cmd_valid;
    logic [2:0]  cmd_mode;
    logic        frame_done;
    logic [15:0] payload;
  } dec_status_t;

endpackage

### sv/fmcp_frame_decoder.sv
module fmcp_frame_decoder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  byte_valid_i,
  input  logic [7:0]            rx_byte_i,
  output fmcp_pkg::dec_status_t dec_o
);

  localparam logic [2:0] PosIdle  = 3'd0;
  localparam logic [2:0] PosCmd   = 3'd1;
  localparam logic [2:0] PosPayHi = 3'd2;
  localparam logic [2:0] PosPayLo = 3'd3;
  localparam logic [2:0] PosFtr   = 3'd4;

  logic [2:0] pos_q, pos_d;
  logic [7:0] pay_hi_q, pay_lo_q;
  logic       cmd_valid;
  logic [2:0] cmd_mode;
  logic       frame_done;

  always_comb begin
    pos_d      = pos_q;
    cmd_valid  = 1'b0;
    cmd_mode   = fmcp_pkg::ModeStop;
    frame_done = 1'b0;
    case (pos_q)
      PosCmd: begin
        cmd_valid = 1'b1;
        case (rx_byte_i)
          fmcp_pkg::CmdSpeed:    cmd_mode = fmcp_pkg::ModeSpeed;
          fmcp_pkg::CmdPosition: cmd_mode = fmcp_pkg::ModePosition;
          fmcp_pkg::CmdVoltage:  cmd_mode = fmcp_pkg::ModeVoltage;
          fmcp_pkg::CmdBrake:    cmd_mode = fmcp_pkg::ModeBrake;
          default:               cmd_valid = 1'b0;
        endcase
        pos_d = cmd_valid ? PosPayHi : PosIdle;
      end
      PosPayHi: pos_d = PosPayLo;
      PosPayLo: pos_d = PosFtr;
      PosFtr: begin
        frame_done = (rx_byte_i == fmcp_pkg::FtrByte);
        pos_d      = PosIdle;
      end
      // idle and unused positions hunt for the header
      default: pos_d = (rx_byte_i == fmcp_pkg::HdrByte) ? PosCmd : PosIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosIdle;
    end else if (byte_valid_i) begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_valid_i && pos_q == PosPayHi) begin
      pay_hi_q <= rx_byte_i;
    end
    if (byte_valid_i && pos_q == PosPayLo) begin
      pay_lo_q <= rx_byte_i;
    end
  end

  assign dec_o.cmd_valid  = byte_valid_i & cmd_valid;
  assign dec_o.cmd_mode   = cmd_mode;
  assign dec_o.frame_done = byte_valid_i & frame_done;
  assign dec_o.payload    = {pay_hi_q, pay_lo_q};

endmodule

### sv/framed_motor_command_parser.sv
// Parses 5-byte motor command frames (header, command, big-endian int16 payload,
// footer) from a stream of received bytes and time ticks, and counts ticks of
// silence against the configurable timeout, dropping to stop mode when it runs
// out. Each accepted request yields exactly one result, held in an output
// register and shown in the cycle after acceptance; a new request is taken every
// cycle while the output register is empty or being drained, so the block
// sustains one request per clock. The timeout register may be written only
// while no result is pending.
`include "framed_motor_command_parser_defines.svh"

module framed_motor_command_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fmcp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fmcp_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i
);

  logic                  in_acc;
  logic                  byte_acc;
  logic                  tick_acc;
  fmcp_pkg::dec_status_t dec;

  logic [15:0] timeout_q;
  logic [2:0]  mode_q, mode_d;
  logic        led_q, led_d;
  logic [15:0] sil_q, sil_d, sil_inc;
  logic [15:0] tgt_q [fmcp_pkg::NumTargets];
  logic        tgt_we;
  logic [1:0]  tgt_idx;
  logic        accepted, fired;
  logic        out_valid_q;
  fmcp_pkg::out_item_t out_q, out_d;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_acc     = in_valid_i & in_ready_o;
  assign byte_acc   = in_acc & (in_data_i.mode == fmcp_pkg::KindByte);
  assign tick_acc   = in_acc & (in_data_i.mode == fmcp_pkg::KindTick);

  fmcp_frame_decoder u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(byte_acc),
    .rx_byte_i   (in_data_i.rx_byte),
    .dec_o       (dec)
  );

  assign sil_inc = (sil_q == fmcp_pkg::SilenceMax) ? sil_q : sil_q + 16'd1;
  assign tgt_idx = 2'(mode_q - 3'd1);

  always_comb begin
    mode_d   = mode_q;
    led_d    = led_q;
    sil_d    = sil_q;
    tgt_we   = 1'b0;
    accepted = 1'b0;
    fired    = 1'b0;
    if (byte_acc) begin
      if (dec.cmd_valid) begin
        mode_d = dec.cmd_mode;
      end
      if (dec.frame_done) begin
        led_d    = 1'b1;
        accepted = 1'b1;
        sil_d    = '0;
        // a frame finished after a fall to stop stores nothing
        tgt_we   = (mode_q != fmcp_pkg::ModeStop);
      end
    end else if (tick_acc) begin
      if (sil_inc > timeout_q) begin
        mode_d = fmcp_pkg::ModeStop;
        led_d  = 1'b0;
        fired  = 1'b1;
        sil_d  = '0;
      end else begin
        sil_d = sil_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= fmcp_pkg::TimeoutResetTicks;
      mode_q    <= fmcp_pkg::ModeStop;
      led_q     <= 1'b0;
      sil_q     <= '0;
      for (int i = 0; i < fmcp_pkg::NumTargets; i++) begin
        tgt_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      mode_q <= mode_d;
      led_q  <= led_d;
      sil_q  <= sil_d;
      if (tgt_we) begin
        tgt_q[tgt_idx] <= dec.payload;
      end
    end
  end

  // result as seen after this request, stores included
  always_comb begin
    out_d.control_mode    = mode_d;
    out_d.speed_target    = tgt_q[0];
    out_d.position_target = tgt_q[1];
    out_d.voltage_target  = tgt_q[2];
    out_d.brake_target    = tgt_q[3];
    if (tgt_we) begin
      case (tgt_idx)
        2'd0:    out_d.speed_target    = dec.payload;
        2'd1:    out_d.position_target = dec.payload;
        2'd2:    out_d.voltage_target  = dec.payload;
        default: out_d.brake_target    = dec.payload;
      endcase
    end
    out_d.frame_accepted = accepted;
    out_d.timed_out      = fired;
    out_d.link_led       = led_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `FMCP_ASSERT_NOW(a_timeout_stops, out_valid_o && out_data_o.timed_out,
    out_data_o.control_mode == fmcp_pkg::ModeStop && !out_data_o.link_led,
    "timeout result without stop mode and cleared link")
  `FMCP_ASSERT_NOW(a_frame_sets_led, out_valid_o && out_data_o.frame_accepted,
    out_data_o.link_led && !out_data_o.timed_out,
    "accepted frame without link indicator")
  `FMCP_ASSERT_NOW(a_mode_range, out_valid_o,
    out_data_o.control_mode == fmcp_pkg::ModeStop ||
    out_data_o.control_mode == fmcp_pkg::ModeSpeed ||
    out_data_o.control_mode == fmcp_pkg::ModePosition ||
    out_data_o.control_mode == fmcp_pkg::ModeVoltage ||
    out_data_o.control_mode == fmcp_pkg::ModeBrake,
    "control mode out of range")
  `FMCP_ASSERT_NEXT(a_tick_result, tick_acc,
    out_valid_o && !out_data_o.frame_accepted,
    "tick request gave no result or a frame acceptance")

endmodule
